/* rtl/cmfs_pkg.sv */
// Shared types and constants for the cube map face selector.
// No dependencies; imported by cmfs_divider and cube_map_face_select.
package cmfs_pkg;

    localparam int FACE_BITS = 3;

    typedef logic [FACE_BITS-1:0] face_t;

    localparam face_t FACE_POS_X = 3'd0;
    localparam face_t FACE_NEG_X = 3'd1;
    localparam face_t FACE_POS_Y = 3'd2;
    localparam face_t FACE_NEG_Y = 3'd3;
    localparam face_t FACE_POS_Z = 3'd4;
    localparam face_t FACE_NEG_Z = 3'd5;

    // Per-transaction information that rides alongside the divider pipeline.
    typedef struct packed {
        logic  zero_vec;
        face_t face;
    } cmfs_side_t;

endpackage

/* rtl/cmfs_divider.sv */
// Pipelined restoring divider: two numerators over one shared divisor, one
// quotient bit per stage. Depends on cmfs_pkg for the sideband struct.
module cmfs_divider #(
    parameter int DIV_BITS = 16,
    parameter int QUO_BITS = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [DIV_BITS:0]       in_num_u,
    input  logic [DIV_BITS:0]       in_num_v,
    input  logic [DIV_BITS-1:0]     in_div,
    input  cmfs_pkg::cmfs_side_t    in_side,
    output logic                    out_valid,
    output logic [QUO_BITS-1:0]     out_quo_u,
    output logic [QUO_BITS-1:0]     out_quo_v,
    output cmfs_pkg::cmfs_side_t    out_side
);
    import cmfs_pkg::*;

    localparam int REM_BITS = DIV_BITS + 1;

    logic                valid_reg [QUO_BITS];
    logic [QUO_BITS-1:0] quo_u_reg [QUO_BITS];
    logic [QUO_BITS-1:0] quo_v_reg [QUO_BITS];
    cmfs_side_t          side_reg  [QUO_BITS];
    logic [REM_BITS-1:0] rem_u_reg [QUO_BITS-1];
    logic [REM_BITS-1:0] rem_v_reg [QUO_BITS-1];
    logic [DIV_BITS-1:0] div_reg   [QUO_BITS-1];

    for (genvar t = 0; t < QUO_BITS; t++) begin : g_stage
        logic                v_in;
        logic [REM_BITS-1:0] ru_in;
        logic [REM_BITS-1:0] rv_in;
        logic [DIV_BITS-1:0] d_in;
        logic [QUO_BITS-1:0] qu_in;
        logic [QUO_BITS-1:0] qv_in;
        cmfs_side_t          s_in;
        logic [REM_BITS-1:0] d_cmp;
        logic                ge_u;
        logic                ge_v;

        if (t == 0) begin : g_first
            assign v_in  = in_valid;
            assign ru_in = in_num_u;
            assign rv_in = in_num_v;
            assign d_in  = in_div;
            assign qu_in = '0;
            assign qv_in = '0;
            assign s_in  = in_side;
            // Top quotient bit: does the numerator reach twice the divisor
            assign d_cmp = {in_div, 1'b0};
        end
        else if (t == 1) begin : g_second
            assign v_in  = valid_reg[t-1];
            assign ru_in = rem_u_reg[t-1];
            assign rv_in = rem_v_reg[t-1];
            assign d_in  = div_reg[t-1];
            assign qu_in = quo_u_reg[t-1];
            assign qv_in = quo_v_reg[t-1];
            assign s_in  = side_reg[t-1];
            assign d_cmp = {1'b0, div_reg[t-1]};
        end
        else begin : g_rest
            assign v_in  = valid_reg[t-1];
            // Remainder is below the divisor here, so doubling stays in range
            assign ru_in = {rem_u_reg[t-1][REM_BITS-2:0], 1'b0};
            assign rv_in = {rem_v_reg[t-1][REM_BITS-2:0], 1'b0};
            assign d_in  = div_reg[t-1];
            assign qu_in = quo_u_reg[t-1];
            assign qv_in = quo_v_reg[t-1];
            assign s_in  = side_reg[t-1];
            assign d_cmp = {1'b0, div_reg[t-1]};
        end

        assign ge_u = (ru_in >= d_cmp);
        assign ge_v = (rv_in >= d_cmp);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[t] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[t] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_u_reg[t] <= {qu_in[QUO_BITS-2:0], ge_u};
                quo_v_reg[t] <= {qv_in[QUO_BITS-2:0], ge_v};
                side_reg[t]  <= s_in;
            end
        end

        if (t < QUO_BITS - 1) begin : g_keep_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_u_reg[t] <= ge_u ? (ru_in - d_cmp) : ru_in;
                    rem_v_reg[t] <= ge_v ? (rv_in - d_cmp) : rv_in;
                    div_reg[t]   <= d_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_BITS-1];
    assign out_quo_u = quo_u_reg[QUO_BITS-1];
    assign out_quo_v = quo_v_reg[QUO_BITS-1];
    assign out_side  = side_reg[QUO_BITS-1];

endmodule

/* rtl/cube_map_face_select.sv */
// Cube map face selector: picks the major axis of a signed direction vector
// and returns the face (0 +X, 1 -X, 2 +Y, 3 -Y, 4 +Z, 5 -Z) with its two
// face coordinates floor((m + s) * 2^(COORD_BITS-1) / m), saturated, where m
// is the major magnitude and s the signed minor; ties go to x, then y, then
// z, and a zero vector gives +Y at the face center. One transaction is taken
// every cycle unless the pipeline is frozen; the path runs through three front
// stages, one divider stage per quotient bit (COORD_BITS + 1) and the output
// register. Out_stall, while out_valid is high, freezes the whole pipeline
// and shows up on in_stall in the same cycle.
// Depends on cmfs_pkg and cmfs_divider.
module cube_map_face_select #(
    parameter int COMPONENT_BITS = 16,
    parameter int COORD_BITS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COMPONENT_BITS-1:0]  dir_x,
    input  logic signed [COMPONENT_BITS-1:0]  dir_y,
    input  logic signed [COMPONENT_BITS-1:0]  dir_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output cmfs_pkg::face_t                   face,
    output logic [COORD_BITS-1:0]             tex_u,
    output logic [COORD_BITS-1:0]             tex_v
);
    import cmfs_pkg::*;

    localparam int N        = COMPONENT_BITS;
    localparam int QUO_BITS = COORD_BITS + 1;
    localparam logic [COORD_BITS-1:0] COORD_HALF = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic en;

    // Stage 1: magnitudes
    logic                s1_valid_reg;
    logic signed [N-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [N-1:0]        s1_ax_reg, s1_ay_reg, s1_az_reg;

    // Stage 2: major axis and signed minors
    logic                s2_valid_reg;
    logic [N-1:0]        s2_major_reg;
    logic signed [N:0]   s2_su_reg, s2_sv_reg;
    cmfs_side_t          s2_side_reg;
    logic [N-1:0]        s2_major_next;
    logic signed [N:0]   s2_su_next, s2_sv_next;
    cmfs_side_t          s2_side_next;

    // Stage 3: numerators
    logic                s3_valid_reg;
    logic [N-1:0]        s3_major_reg;
    logic [N:0]          s3_num_u_reg, s3_num_v_reg;
    cmfs_side_t          s3_side_reg;
    logic signed [N+1:0] sum_u, sum_v;

    // Divider outputs
    logic                div_valid;
    logic [QUO_BITS-1:0] div_quo_u, div_quo_v;
    cmfs_side_t          div_side;

    // Output register
    logic                  out_valid_reg;
    face_t                 face_reg;
    logic [COORD_BITS-1:0] tex_u_reg, tex_v_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    function automatic logic [N-1:0] abs_val(input logic signed [N-1:0] a);
        // Most negative value comes out as 2^(N-1), read unsigned
        abs_val = a[N-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic signed [N:0] neg_ext(input logic signed [N-1:0] a);
        neg_ext = -$signed({a[N-1], a});
    endfunction

    function automatic logic signed [N:0] pos_ext(input logic signed [N-1:0] a);
        pos_ext = $signed({a[N-1], a});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg  <= dir_x;
            s1_y_reg  <= dir_y;
            s1_z_reg  <= dir_z;
            s1_ax_reg <= abs_val(dir_x);
            s1_ay_reg <= abs_val(dir_y);
            s1_az_reg <= abs_val(dir_z);
        end
    end

    always_comb
    begin
        s2_side_next.zero_vec = (s1_ax_reg == '0) && (s1_ay_reg == '0) && (s1_az_reg == '0);
        if (s1_ax_reg >= s1_ay_reg && s1_ax_reg >= s1_az_reg)
        begin
            s2_major_next = s1_ax_reg;
            s2_sv_next    = neg_ext(s1_y_reg);
            if (s1_x_reg > 0)
            begin
                s2_side_next.face = FACE_POS_X;
                s2_su_next        = neg_ext(s1_z_reg);
            end
            else
            begin
                s2_side_next.face = FACE_NEG_X;
                s2_su_next        = pos_ext(s1_z_reg);
            end
        end
        else if (s1_ay_reg >= s1_az_reg)
        begin
            s2_major_next = s1_ay_reg;
            s2_su_next    = pos_ext(s1_x_reg);
            if (s1_y_reg > 0)
            begin
                s2_side_next.face = FACE_POS_Y;
                s2_sv_next        = pos_ext(s1_z_reg);
            end
            else
            begin
                s2_side_next.face = FACE_NEG_Y;
                s2_sv_next        = neg_ext(s1_z_reg);
            end
        end
        else
        begin
            s2_major_next = s1_az_reg;
            s2_sv_next    = neg_ext(s1_y_reg);
            if (s1_z_reg > 0)
            begin
                s2_side_next.face = FACE_POS_Z;
                s2_su_next        = pos_ext(s1_x_reg);
            end
            else
            begin
                s2_side_next.face = FACE_NEG_Z;
                s2_su_next        = neg_ext(s1_x_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_major_reg <= s2_major_next;
            s2_su_reg    <= s2_su_next;
            s2_sv_reg    <= s2_sv_next;
            s2_side_reg  <= s2_side_next;
        end
    end

    assign sum_u = $signed({2'b00, s2_major_reg}) + $signed({s2_su_reg[N], s2_su_reg});
    assign sum_v = $signed({2'b00, s2_major_reg}) + $signed({s2_sv_reg[N], s2_sv_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_major_reg <= s2_major_reg;
            // Clamp at zero; the minor never exceeds the major in magnitude
            s3_num_u_reg <= sum_u[N+1] ? '0 : sum_u[N:0];
            s3_num_v_reg <= sum_v[N+1] ? '0 : sum_v[N:0];
            s3_side_reg  <= s2_side_reg;
        end
    end

    cmfs_divider #(
        .DIV_BITS (N),
        .QUO_BITS (QUO_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_num_u  (s3_num_u_reg),
        .in_num_v  (s3_num_v_reg),
        .in_div    (s3_major_reg),
        .in_side   (s3_side_reg),
        .out_valid (div_valid),
        .out_quo_u (div_quo_u),
        .out_quo_v (div_quo_v),
        .out_side  (div_side)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (div_side.zero_vec)
            begin
                face_reg  <= FACE_POS_Y;
                tex_u_reg <= COORD_HALF;
                tex_v_reg <= COORD_HALF;
            end
            else
            begin
                face_reg  <= div_side.face;
                // Only a quotient of exactly 2^COORD_BITS sets the top bit
                tex_u_reg <= div_quo_u[QUO_BITS-1] ? '1 : div_quo_u[COORD_BITS-1:0];
                tex_v_reg <= div_quo_v[QUO_BITS-1] ? '1 : div_quo_v[COORD_BITS-1:0];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign face      = face_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;

endmodule
